// ----- design/stb_pkg.sv -----
`timescale 1ns / 1ps
package stb_pkg;

	localparam int MAX_RES = 16;

	typedef enum logic [2:0] {
		REQ_CREATE = 3'd0,
		REQ_START  = 3'd1,
		REQ_STOP   = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_TICK   = 3'd4
	} req_type_t;

	typedef enum logic [3:0] {
		ST_OK           = 4'd0,
		ST_BAD_HANDLE   = 4'd1,
		ST_NOT_CREATED  = 4'd2,
		ST_NO_FREE      = 4'd3,
		ST_BAD_INTERVAL = 4'd4,
		ST_RUNNING      = 4'd5,
		ST_NOT_RUNNING  = 4'd6,
		ST_EXPIRED      = 4'd7,
		ST_NO_EXPIRY    = 4'd8
	} status_t;

	// one timer slot as it travels around the ring
	typedef struct packed {
		logic        used;
		logic        running;
		logic        reload;
		logic        done;
		logic [31:0] period;
		logic [31:0] deadline;
	} slot_rec_t;

endpackage

// ----- design/stb_if.sv -----
`timescale 1ns / 1ps
interface stb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [7:0]  handle;
	logic        timer_mode;
	logic [31:0] interval;

	modport source (output valid, req_type, handle, timer_mode, interval, input ready);
	modport sink (input valid, req_type, handle, timer_mode, interval, output ready);
endinterface

interface stb_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [3:0] timer_index;
	logic       last;

	modport source (output valid, status, timer_index, last, input ready);
	modport sink (input valid, status, timer_index, last, output ready);
endinterface

// ----- design/stb_cell.sv -----
`timescale 1ns / 1ps
module stb_cell import stb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  slot_rec_t rec_in,
	output slot_rec_t rec_out
);

	slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= rec_in;
		end
	end

	assign rec_out = rec_q;

endmodule

// ----- design/software_timer_bank.sv -----
`timescale 1ns / 1ps
// create, start, stop and delete take one ring lap, then the result goes through the emit state to
// the output register; a bad handle or bad interval skips the lap and goes straight to emit
// tick: one lap to find the oldest expiry, then per expiry a lap that fires it and finds the next,
// followed by an emit beat; at most 16 expiries are reported per tick
// throughput: one item at a time; the next item is taken once the last beat is registered
// reset: all slots free and stopped, tick counter zero, interval_limit 0x80000000
module software_timer_bank import stb_pkg::*; #(
	parameter int TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	stb_in_if.sink      req,
	stb_out_if.source   rsp
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [8:0] NUM_T = 9'(TIMERS);
	localparam logic [IW-1:0] LAST_S = IW'(TIMERS - 1);

	typedef enum logic [1:0] {S_IDLE, S_LAP, S_EMIT} state_t;

	state_t         state_q;
	logic [2:0]     op_q;
	logic [7:0]     h_q;
	logic           mode_q;
	logic [31:0]    iv_q;
	logic [31:0]    limit_q;
	logic [31:0]    now_q;
	logic [IW-1:0]  s_q;
	logic           found_q;
	logic [IW-1:0]  best_idx_q;
	logic [31:0]    best_age_q;
	logic           have_prev_q;
	logic [IW-1:0]  prev_idx_q;
	logic           first_q;
	logic [4:0]     cnt_q;
	status_t        st_q;
	// beat waiting for the output register
	status_t        e_status_q;
	logic [3:0]     e_idx_q;
	logic           e_last_q;
	logic           more_q;
	// output register
	logic           ov_q;
	status_t        o_status_q;
	logic [3:0]     o_idx_q;
	logic           o_last_q;

	// ring of slot cells, cell 0 faces the head unit
	slot_rec_t chain [TIMERS];
	slot_rec_t head_rec;
	logic      shift;

	assign shift = (state_q == S_LAP);

	for (genvar i = 0; i < TIMERS; i++) begin : g_cell
		slot_rec_t nxt;
		if (i == TIMERS - 1) begin : g_tail
			assign nxt = head_rec;
		end else begin : g_mid
			assign nxt = chain[i + 1];
		end
		stb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.rec_in (nxt),
			.rec_out(chain[i])
		);
	end

	// head unit: acts on the record passing cell 0, index is the lap step
	slot_rec_t   rec0;
	logic [31:0] age;
	logic [31:0] rearm;
	logic        hit;
	logic        take;
	logic        fire;
	logic        better;
	status_t     stat;

	always_comb begin
		rec0     = chain[0];
		head_rec = rec0;
		age      = now_q - rec0.deadline;
		rearm    = now_q + rec0.period;
		hit      = (h_q == 8'(s_q));
		take     = 1'b0;
		fire     = 1'b0;
		better   = 1'b0;
		stat     = ST_NOT_CREATED;
		case (op_q)
			REQ_CREATE: begin
				if (!found_q && !rec0.used) begin
					take             = 1'b1;
					head_rec.used    = 1'b1;
					head_rec.running = 1'b0;
					head_rec.reload  = mode_q;
					head_rec.period  = iv_q;
				end
			end
			REQ_START: begin
				if (!rec0.used) begin
					stat = ST_NOT_CREATED;
				end else if (rec0.running) begin
					stat = ST_RUNNING;
				end else begin
					stat = ST_OK;
					if (hit) begin
						head_rec.running  = 1'b1;
						head_rec.deadline = rearm;
					end
				end
			end
			REQ_STOP: begin
				if (!rec0.used) begin
					stat = ST_NOT_CREATED;
				end else if (!rec0.running) begin
					stat = ST_NOT_RUNNING;
				end else begin
					stat = ST_OK;
					if (hit) begin
						head_rec.running = 1'b0;
					end
				end
			end
			REQ_DELETE: begin
				if (!rec0.used) begin
					stat = ST_NOT_CREATED;
				end else begin
					stat = ST_OK;
					if (hit) begin
						head_rec.used    = 1'b0;
						head_rec.running = 1'b0;
					end
				end
			end
			REQ_TICK: begin
				// the slot found on the previous lap fires now
				fire          = have_prev_q && (s_q == prev_idx_q);
				head_rec.done = fire | (!first_q & rec0.done);
				if (fire) begin
					if (rec0.reload) begin
						head_rec.deadline = rearm;
					end else begin
						head_rec.running = 1'b0;
					end
				end
				// oldest first, equal age keeps the lower index seen earlier
				better = !fire && rec0.running && !(!first_q && rec0.done) && !age[31]
					&& (!found_q || (age > best_age_q));
			end
			default: begin
			end
		endcase
	end

	logic          lap_end;
	logic          any_found;
	logic [IW-1:0] any_idx;
	logic          acc;
	logic          out_free;
	logic          tick_last;

	assign lap_end   = (s_q == LAST_S);
	assign any_found = found_q | take | better;
	assign any_idx   = (take || better) ? s_q : best_idx_q;
	assign acc       = req.valid && req.ready;
	assign out_free  = !ov_q || rsp.ready;
	assign tick_last = !any_found || (cnt_q == 5'(MAX_RES - 1));

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.status      = o_status_q;
	assign rsp.timer_index = o_idx_q;
	assign rsp.last        = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'h8000_0000;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// sequencer: one lap per request (a bad handle or interval skips it), repeated laps for a tick with expiries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			s_q         <= '0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
			first_q     <= 1'b0;
			cnt_q       <= '0;
			more_q      <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			// the emit state loads the output register itself
			if (rsp.ready && (state_q != S_EMIT)) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q        <= req.req_type;
						h_q         <= req.handle;
						mode_q      <= req.timer_mode;
						iv_q        <= req.interval;
						s_q         <= '0;
						found_q     <= 1'b0;
						have_prev_q <= 1'b0;
						first_q     <= 1'b1;
						cnt_q       <= '0;
						st_q        <= ST_NOT_CREATED;
						more_q      <= 1'b0;
						e_idx_q     <= '0;
						e_last_q    <= 1'b1;
						case (req.req_type)
							REQ_CREATE: begin
								if (req.interval >= limit_q) begin
									e_status_q <= ST_BAD_INTERVAL;
									state_q    <= S_EMIT;
								end else begin
									state_q <= S_LAP;
								end
							end
							REQ_START, REQ_STOP, REQ_DELETE: begin
								if ({1'b0, req.handle} >= NUM_T) begin
									e_status_q <= ST_BAD_HANDLE;
									state_q    <= S_EMIT;
								end else begin
									state_q <= S_LAP;
								end
							end
							REQ_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= S_LAP;
							end
							default: begin
							end
						endcase
					end
				end
				S_LAP: begin
					s_q <= lap_end ? '0 : s_q + 1'b1;
					if (hit) begin
						st_q <= stat;
					end
					if (take || better) begin
						best_idx_q <= s_q;
						best_age_q <= age;
					end
					if ((take || better) && !lap_end) begin
						found_q <= 1'b1;
					end
					if (lap_end) begin
						found_q <= 1'b0;
						first_q <= 1'b0;
						case (op_q)
							REQ_CREATE: begin
								e_status_q <= any_found ? ST_OK : ST_NO_FREE;
								e_idx_q    <= any_found ? 4'(any_idx) : 4'd0;
								e_last_q   <= 1'b1;
								more_q     <= 1'b0;
								state_q    <= S_EMIT;
							end
							REQ_TICK: begin
								if (have_prev_q) begin
									e_status_q <= ST_EXPIRED;
									e_idx_q    <= 4'(prev_idx_q);
									e_last_q   <= tick_last;
									more_q     <= !tick_last;
									prev_idx_q <= any_idx;
									cnt_q      <= cnt_q + 5'd1;
									state_q    <= S_EMIT;
								end else if (!any_found) begin
									e_status_q <= ST_NO_EXPIRY;
									e_idx_q    <= '0;
									e_last_q   <= 1'b1;
									more_q     <= 1'b0;
									state_q    <= S_EMIT;
								end else begin
									prev_idx_q  <= any_idx;
									have_prev_q <= 1'b1;
								end
							end
							default: begin
								e_status_q <= hit ? stat : st_q;
								e_idx_q    <= '0;
								e_last_q   <= 1'b1;
								more_q     <= 1'b0;
								state_q    <= S_EMIT;
							end
						endcase
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q       <= 1'b1;
						o_status_q <= e_status_q;
						o_idx_q    <= e_idx_q;
						o_last_q   <= e_last_q;
						state_q    <= more_q ? S_LAP : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
